@@ sv/tkrd_pkg.sv @@
package tkrd_pkg;

   // Text that opens a keyboard status report.
   localparam int PREFIX_LEN = 19;
   localparam int MATCH_W = $clog2(PREFIX_LEN + 1);
   localparam logic [7:0] PREFIX_TEXT [PREFIX_LEN] = '{
      "k", "m", ".", "k", "e", "y", "b", "o", "a", "r",
      "d", "_", "s", "t", "a", "t", "u", "s", "("
   };

   // The only self-overlap of the prefix: the "k" after "km." can restart "km".
   localparam logic [MATCH_W-1:0] KM_REPEAT_POS = MATCH_W'(4);
   localparam logic [MATCH_W-1:0] KM_RESUME_POS = MATCH_W'(2);

   // First usage code of the eight modifier keys.
   localparam logic [7:0] MOD_BASE = 8'hE0;

   // Characters with a meaning to the parser.
   localparam logic [7:0] CHAR_COMMA = ",";
   localparam logic [7:0] CHAR_CLOSE = ")";
   localparam logic [7:0] CHAR_PLUS  = "+";
   localparam logic [7:0] CHAR_MINUS = "-";
   localparam logic [7:0] CHAR_ZERO  = "0";
   localparam logic [7:0] CHAR_NINE  = "9";
   localparam logic [7:0] CHAR_SPACE = " ";
   localparam logic [7:0] CHAR_TAB   = 8'h09;
   localparam logic [7:0] CHAR_CR    = 8'h0D;

   typedef enum logic [1:0] {
      LINE_SEARCH,
      LINE_FIELDS,
      LINE_DONE
   } line_phase_type;

   typedef enum logic [1:0] {
      TOK_SPACE,
      TOK_SIGN,
      TOK_DIGITS,
      TOK_STOP
   } token_phase_type;

   // Report handed from the parser to the key map.
   typedef struct packed {
      logic       apply;
      logic [7:0] mods;
   } report_type;

   // Advance the prefix match by one character, falling back as a substring
   // search does.
   function automatic logic [MATCH_W-1:0] next_match(input logic [MATCH_W-1:0] pos,
                                                     input logic [7:0] ch);
      logic [MATCH_W-1:0] result;
      result = '0;
      if (pos < MATCH_W'(PREFIX_LEN) && PREFIX_TEXT[pos] == ch) begin
         result = pos + MATCH_W'(1);
      end else if (ch == PREFIX_TEXT[0]) begin
         result = MATCH_W'(1);
      end else if (pos == KM_REPEAT_POS && ch == PREFIX_TEXT[1]) begin
         result = KM_RESUME_POS;
      end
      return result;
   endfunction

endpackage

@@ sv/tkrd_parser.sv @@
module tkrd_parser #(
   parameter int FIELD_COUNT = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  logic [7:0]           char_byte,
   input  logic                 end_of_line,
   output tkrd_pkg::report_type report,
   output logic [7:0]           report_codes [FIELD_COUNT-2]
);
   import tkrd_pkg::*;

   localparam int CODES = FIELD_COUNT - 2;
   localparam int FI_W = $clog2(FIELD_COUNT + 1);

   line_phase_type     line_phase_ff, line_phase_in;
   logic [MATCH_W-1:0] match_pos_ff, match_pos_in, match_adv;
   logic [FI_W-1:0]    field_index_ff, field_index_in;
   token_phase_type    tok_phase_ff, tok_phase_in;
   logic               tok_neg_ff, tok_neg_in;
   logic [31:0]        tok_mag_ff, tok_mag_in;
   logic               tok_ovf_ff, tok_ovf_in;
   logic [7:0]         mods_ff, mods_in, mods_cm;
   logic [7:0]         code_ff [CODES];
   logic [7:0]         code_in [CODES];
   logic [7:0]         code_cm [CODES];

   logic        in_fields, is_close, commit, tokenize, clear_line;
   logic        is_digit, is_space, is_sign, num_ok, field_open;
   logic [35:0] prod;
   logic [7:0]  byte_val, code_val;

   assign match_adv  = next_match(match_pos_ff, char_byte);
   assign in_fields  = (line_phase_ff == LINE_FIELDS);
   assign is_close   = (char_byte == CHAR_CLOSE);
   assign commit     = step && in_fields && (char_byte == CHAR_COMMA || is_close);
   assign tokenize   = step && in_fields && !commit;
   assign clear_line = step && end_of_line;
   assign field_open = (field_index_ff < FI_W'(FIELD_COUNT));

   assign is_digit = (char_byte >= CHAR_ZERO) && (char_byte <= CHAR_NINE);
   assign is_space = (char_byte == CHAR_SPACE) ||
                     ((char_byte >= CHAR_TAB) && (char_byte <= CHAR_CR));
   assign is_sign  = (char_byte == CHAR_PLUS) || (char_byte == CHAR_MINUS);

   // Magnitude times ten plus the new digit, kept wide to see a carry out.
   assign prod = ({4'b0, tok_mag_ff} << 3) + ({4'b0, tok_mag_ff} << 1) +
                 {32'b0, char_byte[3:0]};

   // Value of the finished token: the low byte for the modifier field, and a
   // key code only when it lies in 1..255.
   always_comb begin
      num_ok = (tok_phase_ff == TOK_DIGITS) && !tok_ovf_ff &&
               (tok_neg_ff ? (tok_mag_ff <= 32'h8000_0000) : !tok_mag_ff[31]);
      byte_val = '0;
      code_val = '0;
      if (num_ok) begin
         byte_val = tok_neg_ff ? (8'd0 - tok_mag_ff[7:0]) : tok_mag_ff[7:0];
         if (!tok_neg_ff && tok_mag_ff[31:8] == '0) begin
            code_val = tok_mag_ff[7:0];
         end
      end
   end

   // Line phase next state.
   always_comb begin
      line_phase_in = line_phase_ff;
      if (step) begin
         unique case (line_phase_ff)
            LINE_SEARCH: begin
               if (match_adv == MATCH_W'(PREFIX_LEN)) begin
                  line_phase_in = LINE_FIELDS;
               end
            end
            LINE_FIELDS: begin
               if (is_close) begin
                  line_phase_in = LINE_DONE;
               end
            end
            LINE_DONE: begin
               line_phase_in = LINE_DONE;
            end
            default: begin
               line_phase_in = LINE_SEARCH;
            end
         endcase
         if (end_of_line) begin
            line_phase_in = LINE_SEARCH;
         end
      end
   end

   // The closing bracket hands the finished report to the key map.
   always_comb begin
      report.apply = step && in_fields && is_close;
      report.mods  = mods_cm;
   end
   assign report_codes = code_cm;

   // Matcher, tokenizer and field store.
   always_comb begin
      match_pos_in   = match_pos_ff;
      field_index_in = field_index_ff;
      tok_phase_in   = tok_phase_ff;
      tok_neg_in     = tok_neg_ff;
      tok_mag_in     = tok_mag_ff;
      tok_ovf_in     = tok_ovf_ff;
      mods_cm        = mods_ff;
      code_cm        = code_ff;

      if (step && line_phase_ff == LINE_SEARCH) begin
         match_pos_in = match_adv;
      end

      if (commit) begin
         if (field_open) begin
            if (field_index_ff == '0) begin
               mods_cm = byte_val;
            end
            for (int j = 0; j < CODES; j++) begin
               if (field_index_ff == FI_W'(j + 2)) begin
                  code_cm[j] = code_val;
               end
            end
            field_index_in = field_index_ff + FI_W'(1);
         end
         tok_phase_in = TOK_SPACE;
         tok_neg_in   = 1'b0;
         tok_mag_in   = '0;
         tok_ovf_in   = 1'b0;
      end else if (tokenize) begin
         case (tok_phase_ff)
            TOK_SPACE: begin
               if (is_sign) begin
                  tok_neg_in   = (char_byte == CHAR_MINUS);
                  tok_phase_in = TOK_SIGN;
               end else if (is_digit) begin
                  tok_mag_in   = prod[31:0];
                  tok_ovf_in   = tok_ovf_ff | (|prod[35:32]);
                  tok_phase_in = TOK_DIGITS;
               end else if (!is_space) begin
                  tok_phase_in = TOK_STOP;
               end
            end
            TOK_SIGN, TOK_DIGITS: begin
               if (is_digit) begin
                  tok_mag_in   = prod[31:0];
                  tok_ovf_in   = tok_ovf_ff | (|prod[35:32]);
                  tok_phase_in = TOK_DIGITS;
               end else begin
                  tok_phase_in = TOK_STOP;
               end
            end
            default: begin
               tok_phase_in = TOK_STOP;
            end
         endcase
      end

      mods_in = mods_cm;
      code_in = code_cm;

      // The end of a line returns everything but the key map to reset.
      if (clear_line) begin
         match_pos_in   = '0;
         field_index_in = '0;
         tok_phase_in   = TOK_SPACE;
         tok_neg_in     = 1'b0;
         tok_mag_in     = '0;
         tok_ovf_in     = 1'b0;
         mods_in        = '0;
         for (int j = 0; j < CODES; j++) begin
            code_in[j] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_phase_ff  <= LINE_SEARCH;
         match_pos_ff   <= '0;
         field_index_ff <= '0;
         tok_phase_ff   <= TOK_SPACE;
         tok_neg_ff     <= 1'b0;
         tok_mag_ff     <= '0;
         tok_ovf_ff     <= 1'b0;
         mods_ff        <= '0;
         for (int j = 0; j < CODES; j++) begin
            code_ff[j] <= '0;
         end
      end else begin
         line_phase_ff  <= line_phase_in;
         match_pos_ff   <= match_pos_in;
         field_index_ff <= field_index_in;
         tok_phase_ff   <= tok_phase_in;
         tok_neg_ff     <= tok_neg_in;
         tok_mag_ff     <= tok_mag_in;
         tok_ovf_ff     <= tok_ovf_in;
         mods_ff        <= mods_in;
         code_ff        <= code_in;
      end
   end

endmodule

@@ sv/text_keyboard_report_decoder.sv @@
// Decodes text lines that carry a keyboard status report: a fixed 19-character
// opening text, then the fields m,r,k2,...,kN and a closing bracket, taken
// one character per transfer. It keeps the set of pressed keys from the last
// complete report. Each accepted character yields exactly one result in the
// next cycle: key_down tells whether the queried usage code is pressed after
// that character, and report_applied marks the ')' that replaced the key set.
// A new character is taken every cycle while the result side keeps up; the
// single result register sets that rate. The key set is held as the modifier
// byte and the FIELD_COUNT-2 key codes of the last report, not as a 256-entry
// map, so a query is a handful of byte compares.
module text_keyboard_report_decoder #(
   parameter int FIELD_COUNT = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // [7:0] char_byte, [15:8] query_code
   input  logic        req_tlast,  // end_of_line
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata   // [0] key_down, [1] report_applied, rest zero
);
   import tkrd_pkg::*;

   localparam int CODES = FIELD_COUNT - 2;

   logic       step;
   logic [7:0] query_code;
   report_type report;
   logic [7:0] report_codes [CODES];

   logic [7:0] snap_mods_ff, snap_mods_in;
   logic [7:0] snap_code_ff [CODES];
   logic [7:0] snap_code_in [CODES];
   logic       key_hit;
   logic       rsp_valid_ff, rsp_key_ff, rsp_applied_ff;

   // A character is taken whenever the result register is free or draining.
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign step       = req_tvalid && req_tready;
   assign query_code = req_tdata[15:8];

   tkrd_parser #(
      .FIELD_COUNT(FIELD_COUNT)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .char_byte   (req_tdata[7:0]),
      .end_of_line (req_tlast),
      .report      (report),
      .report_codes(report_codes)
   );

   // Key set after this character: a closing bracket replaces it.
   always_comb begin
      snap_mods_in = snap_mods_ff;
      snap_code_in = snap_code_ff;
      if (report.apply) begin
         snap_mods_in = report.mods;
         snap_code_in = report_codes;
      end
   end

   // A code is pressed when it is a set modifier bit or a listed nonzero key.
   always_comb begin
      key_hit = (query_code[7:3] == MOD_BASE[7:3]) && snap_mods_in[query_code[2:0]];
      for (int j = 0; j < CODES; j++) begin
         if (snap_code_in[j] != '0 && snap_code_in[j] == query_code) begin
            key_hit = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         snap_mods_ff <= '0;
         for (int j = 0; j < CODES; j++) begin
            snap_code_ff[j] <= '0;
         end
      end else if (step) begin
         snap_mods_ff <= snap_mods_in;
         snap_code_ff <= snap_code_in;
      end
   end

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (step) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         rsp_key_ff     <= key_hit;
         rsp_applied_ff <= report.apply;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_applied_ff, rsp_key_ff};

endmodule

@@ verif/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import tkrd_pkg::*;

   localparam int    FIELDS       = 8;
   localparam string REPORT_OPEN  = {"km.keyboard", "_status("};
   localparam int    OPEN_LEN     = 19;
   localparam int    RANDOM_CHARS = 1350;

   // One character transfer and the usage code to query with it.
   typedef struct packed {
      bit [7:0] ch;
      bit       eol;
      bit [7:0] query;
   } char_item_type;

   typedef struct packed {
      bit key_down;
      bit report_applied;
   } key_status_type;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_PERIODIC,
      READY_SPARSE
   } ready_mode_type;

   logic        clock;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        req_tlast  = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;

   char_item_type  pending_chars[$];
   key_status_type expected_status[$];
   bit [7:0]       line_buf[$];
   bit [7:0]       code_pool[$];

   int mismatches      = 0;
   int chars_sent      = 0;
   int lines_made      = 0;
   int reports_applied = 0;

   // Shadow of the decoder state.
   int              match_len;
   line_phase_type  line_st;
   int              field_no;
   token_phase_type tok_st;
   bit              tok_neg;
   bit [31:0]       tok_mag;
   bit              tok_ovf;
   bit [7:0]        field_val [FIELDS];
   bit [255:0]      key_map;

   text_keyboard_report_decoder #(.FIELD_COUNT(FIELDS)) dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),   // [7:0] char_byte, [15:8] query_code
      .req_tlast  (req_tlast),   // end_of_line
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)    // [0] key_down, [1] report_applied, rest zero
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Key status predictor
   // ------------------------------------------------------------------

   function automatic void clear_token();
      tok_st  = TOK_SPACE;
      tok_neg = 1'b0;
      tok_mag = '0;
      tok_ovf = 1'b0;
   endfunction

   function automatic void restart_line();
      match_len = 0;
      line_st   = LINE_SEARCH;
      field_no  = 0;
      clear_token();
      foreach (field_val[i]) field_val[i] = '0;
   endfunction

   // Convert the finished token the way a string-to-int conversion does and store it.
   function automatic void close_field();
      longint v;
      v = 0;
      if (tok_st == TOK_DIGITS && !tok_ovf) begin
         if (tok_neg) begin
            if (tok_mag <= 32'h8000_0000) v = -longint'(tok_mag);
         end else if (tok_mag <= 32'h7FFF_FFFF) begin
            v = longint'(tok_mag);
         end
      end
      if (field_no < FIELDS) begin
         if (field_no < 2) field_val[field_no] = v[7:0];
         else field_val[field_no] = (v >= 1 && v <= 255) ? v[7:0] : 8'd0;
         field_no++;
      end
      clear_token();
   endfunction

   function automatic key_status_type decode_char(bit [7:0] c, bit eol, bit [7:0] q);
      key_status_type r;
      int          next_len;
      int          len;
      int          j;
      bit          ok;
      bit          digit;
      bit          space;
      bit          take;
      bit [63:0]   wide;
      r.report_applied = 1'b0;
      digit = (c >= CHAR_ZERO && c <= CHAR_NINE);
      space = (c == CHAR_SPACE || (c >= CHAR_TAB && c <= CHAR_CR));
      take  = 1'b0;
      case (line_st)
         LINE_SEARCH: begin
            // Substring search: on a miss fall back to the longest border that still fits.
            if (match_len < OPEN_LEN && REPORT_OPEN[match_len] == c) begin
               match_len++;
            end else begin
               next_len = 0;
               for (len = match_len; len >= 1 && next_len == 0; len--) begin
                  if (REPORT_OPEN[len-1] == c) begin
                     ok = 1'b1;
                     for (j = 0; j < len - 1; j++)
                        if (REPORT_OPEN[j] != REPORT_OPEN[match_len-len+1+j]) ok = 1'b0;
                     if (ok) next_len = len;
                  end
               end
               match_len = next_len;
            end
            if (match_len >= OPEN_LEN) begin
               restart_line();
               line_st = LINE_FIELDS;
            end
         end
         LINE_FIELDS: begin
            if (c == CHAR_COMMA) begin
               close_field();
            end else if (c == CHAR_CLOSE) begin
               close_field();
               key_map = '0;
               for (j = 0; j < 8; j++)
                  if (field_val[0][j]) key_map[MOD_BASE + j] = 1'b1;
               for (j = 2; j < FIELDS; j++)
                  if (field_val[j] != 0) key_map[field_val[j]] = 1'b1;
               r.report_applied = 1'b1;
               line_st = LINE_DONE;
               reports_applied++;
            end else begin
               case (tok_st)
                  TOK_SPACE: begin
                     if (space) begin
                     end else if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        tok_neg = (c == CHAR_MINUS);
                        tok_st  = TOK_SIGN;
                     end else if (!digit) begin
                        tok_st = TOK_STOP;
                     end else begin
                        take = 1'b1;
                     end
                  end
                  TOK_SIGN, TOK_DIGITS: begin
                     if (!digit) tok_st = TOK_STOP;
                     else take = 1'b1;
                  end
                  default: begin
                  end
               endcase
               if (take) begin
                  wide = 64'(tok_mag) * 64'd10 + 64'(c - CHAR_ZERO);
                  if (wide > 64'hFFFF_FFFF) tok_ovf = 1'b1;
                  tok_mag = wide[31:0];
                  tok_st  = TOK_DIGITS;
               end
            end
         end
         default: begin
         end
      endcase
      if (eol) restart_line();
      r.key_down = key_map[q];
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Line generator
   // ------------------------------------------------------------------

   // Append one character to the line being built.
   function automatic void put_char(bit [7:0] b);
      line_buf.insert(line_buf.size(), b);
   endfunction

   function automatic void put_str(string s);
      for (int i = 0; i < s.len(); i++) put_char(s[i]);
   endfunction

   function automatic void put_space();
      int n;
      bit [7:0] ws;
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0;
      for (int i = 0; i < n; i++) begin
         ws = ($urandom_range(0, 1) == 0) ? CHAR_SPACE : 8'($urandom_range(CHAR_TAB, CHAR_CR));
         put_char(ws);
      end
   endfunction

   function automatic bit [7:0] pick_query();
      int r;
      r = $urandom_range(0, 9);
      if (r < 4 || code_pool.size() == 0 && r >= 6) return 8'($urandom_range(0, 255));
      if (r < 6) return MOD_BASE + 8'($urandom_range(0, 7));
      return code_pool[$urandom_range(0, code_pool.size() - 1)];
   endfunction

   // Move the line buffer into the pending queue, marking its last character.
   function automatic void flush_line();
      char_item_type it;
      for (int i = 0; i < line_buf.size(); i++) begin
         it.ch    = line_buf[i];
         it.eol   = (i == line_buf.size() - 1);
         it.query = pick_query();
         pending_chars.insert(pending_chars.size(), it);
      end
      line_buf.delete();
      lines_made++;
   endfunction

   function automatic void put_field(int idx);
      string    limit_texts[12] = '{"2147483647", "2147483648", "-2147483648", "-2147483649",
                                    "4294967295", "4294967296", "4294967306", "99999999999",
                                    "+255", "-0", "000000000000000000000255", "256"};
      string    junk_texts[10]  = '{"+", "-", "x12", "+-3", "--1", "7 9", " ", "0x1F",
                                    "+ 5", "a"};
      bit [7:0] code;
      int       kind;
      kind = $urandom_range(0, 9);
      if (idx == 0 && $urandom_range(0, 2) != 0) begin
         put_space();
         put_str($sformatf("%0d", $urandom_range(0, 255)));
         return;
      end
      case (kind)
         0: begin
         end
         1, 2, 3: begin
            put_space();
            if ($urandom_range(0, 7) == 0) put_char(CHAR_PLUS);
            code = 8'($urandom_range(1, 255));
            code_pool.insert(code_pool.size(), code);
            if (code_pool.size() > 16) void'(code_pool.pop_front());
            put_str($sformatf("%0d", code));
         end
         4: begin
            put_space();
            put_char(CHAR_MINUS);
            put_str($sformatf("%0d", $urandom_range(0, 300)));
         end
         5: begin
            put_space();
            if ($urandom_range(0, 1) == 0) put_char(CHAR_MINUS);
            put_str($sformatf("%0d", longint'($urandom)));
         end
         6: put_str(limit_texts[$urandom_range(0, 11)]);
         7: put_str(junk_texts[$urandom_range(0, 9)]);
         8: begin
            // Digits followed by trailing characters that the conversion ignores.
            code = 8'($urandom_range(1, 255));
            code_pool.insert(code_pool.size(), code);
            put_str($sformatf("%0d", code));
            put_char(8'($urandom_range("a", "z")));
            if ($urandom_range(0, 1) == 0) put_str($sformatf("%0d", $urandom_range(0, 99)));
         end
         default: begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
               put_char(8'($urandom_range(0, 255)));
         end
      endcase
   endfunction

   function automatic void make_line();
      string fragments[8];
      int sel;
      int nf;
      int bad;
      // Partial and repeated pieces of the opening text.
      fragments = '{"km.", "km.k", {"km.", REPORT_OPEN.substr(0, OPEN_LEN - 2)}, "kkm.",
                    REPORT_OPEN.substr(0, OPEN_LEN - 3), REPORT_OPEN.substr(0, OPEN_LEN - 2),
                    "km.kekm.", "k"};
      sel = $urandom_range(0, 99);
      if (sel < 12) begin
         // Raw noise over the whole byte range.
         for (int i = $urandom_range(1, 24); i > 0; i--)
            put_char(8'($urandom_range(0, 255)));
      end else begin
         case ($urandom_range(0, 3))
            1: for (int i = $urandom_range(1, 5); i > 0; i--)
                  put_char(8'($urandom_range(32, 126)));
            2: put_str(REPORT_OPEN.substr(0, $urandom_range(0, OPEN_LEN - 2)));
            3: put_str(fragments[$urandom_range(0, 7)]);
            default: begin
            end
         endcase
         if (sel < 24) begin
            // Damaged opening text: one character replaced, dropped, or the text cut short.
            bad = $urandom_range(0, OPEN_LEN - 1);
            for (int i = 0; i < OPEN_LEN; i++) begin
               if (i != bad) put_char(REPORT_OPEN[i]);
               else if (sel < 16) put_char(8'($urandom_range(0, 255)));
               else if (sel < 20) break;
            end
         end else begin
            put_str(REPORT_OPEN);
         end
         nf = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 11) : $urandom_range(2, 8);
         for (int i = 0; i < nf; i++) begin
            if (i > 0) put_char(CHAR_COMMA);
            put_field(i);
         end
         if ($urandom_range(0, 9) != 0) put_char(CHAR_CLOSE);
         for (int i = $urandom_range(0, 4); i > 0; i--)
            put_char(8'($urandom_range(32, 126)));
      end
      if (line_buf.size() == 0) put_char(8'($urandom_range(0, 255)));
      flush_line();
   endfunction

   // ------------------------------------------------------------------
   // Driver: bursts of transfers separated by random gaps
   // ------------------------------------------------------------------

   int             burst_left = 0;
   int             gap_left   = 0;
   char_item_type  next_char;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_status.insert(expected_status.size(),
                                   decode_char(req_tdata[7:0], req_tlast, req_tdata[15:8]));
            chars_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (pending_chars.size() != 0) begin
               next_char = pending_chars.pop_front();
               req_tdata  <= {next_char.query, next_char.ch};
               req_tlast  <= next_char.eol;
               req_tvalid <= 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200)
                                                           : $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Receiver backpressure: modes that change at random
   // ------------------------------------------------------------------

   ready_mode_type ready_mode = READY_ALWAYS;
   int             mode_left  = 0;

   always @(posedge clock) begin
      if (mode_left == 0) begin
         ready_mode = ready_mode_type'($urandom_range(0, 3));
         mode_left  = $urandom_range(8, 64);
      end else begin
         mode_left--;
      end
      case (ready_mode)
         READY_ALWAYS:   rsp_tready <= 1'b1;
         READY_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
         READY_PERIODIC: rsp_tready <= (mode_left % 3) != 0;
         default:        rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   // ------------------------------------------------------------------
   // Monitor: compare each result transfer with the oldest prediction
   // ------------------------------------------------------------------

   key_status_type want;

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_status.size() == 0) begin
            $error("Result transfer with nothing expected: rsp_tdata=%h", rsp_tdata);
            mismatches++;
         end else begin
            want = expected_status.pop_front();
            if (rsp_tdata[0] !== want.key_down) begin
               $error("key_down: expected %0b, actual %0b", want.key_down, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.report_applied) begin
               $error("report_applied: expected %0b, actual %0b",
                      want.report_applied, rsp_tdata[1]);
               mismatches++;
            end
            if (rsp_tdata[7:2] !== 6'd0) begin
               $error("rsp_tdata[7:2]: expected 0, actual %h", rsp_tdata[7:2]);
               mismatches++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus and end of run
   // ------------------------------------------------------------------

   initial begin
      key_map = '0;
      restart_line();
      // Directed: all modifier bits from -1, the highest code, a character after the report.
      put_str({REPORT_OPEN, "-1,0,255)"});
      put_char(8'hFF);
      flush_line();
      // Directed: an empty report clears everything, then a bare end of line.
      put_str({REPORT_OPEN, ")"});
      flush_line();
      put_char(8'h00);
      flush_line();
      while (pending_chars.size() < RANDOM_CHARS + 50) make_line();

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (pending_chars.size() != 0 || req_tvalid || expected_status.size() != 0)
         @(posedge clock);
      repeat (16) @(posedge clock);

      $display("Sent %0d characters in %0d lines; %0d reports rebuilt the key map.",
               chars_sent, lines_made, reports_applied);
      if (mismatches == 0) begin
         $display("[text_keyboard_report_decoder] OK");
      end else begin
         $display("[text_keyboard_report_decoder] ERROR");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Timed out with %0d results outstanding.", expected_status.size());
      $display("[text_keyboard_report_decoder] ERROR");
      $finish;
   end

endmodule

@@ text_keyboard_report_decoder.f @@
sv/tkrd_pkg.sv
sv/tkrd_parser.sv
sv/text_keyboard_report_decoder.sv
verif/tb.sv
